@@ sv/assert_macros.svh @@
// Assertion macros shared by the odometry RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a consequence at the same edge.
`define ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// Check that a condition implies a consequence at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

@@ sv/ddo_pkg.sv @@
// Package with shared types, constants and the arctangent table for the odometry.
package ddo_pkg;

    localparam int CordicSteps = 16;
    localparam int TableLen    = 30;
    localparam int NumCells    = (CordicSteps < TableLen) ? CordicSteps : TableLen;
    localparam int StepW       = $clog2(NumCells + 1);

    localparam logic [33:0] GainQ30 = 34'd652032875;
    localparam logic [23:0] DptReset = 24'd103585;
    localparam logic [23:0] HptReset = 24'd723917;

    localparam logic [1:0] RegDistancePerTic = 2'd0;
    localparam logic [1:0] RegHeadingPerTic  = 2'd1;

    typedef struct packed {
        logic signed [15:0] right_tics;
        logic signed [15:0] left_tics;
        logic               right_reverse;
        logic               left_reverse;
        logic               clear_distance;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] position_x;
        logic signed [31:0] position_y;
        logic        [31:0] heading_angle;
        logic signed [31:0] path_distance;
    } out_item_t;

    // One CORDIC vector travelling down the chain of cells.
    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
    } cordic_vec_t;

    function automatic logic signed [33:0] atan_entry(input int i);
        logic [31:0] v;
        begin
            case (i)
                0:  v = 32'h20000000;
                1:  v = 32'h12E4051D;
                2:  v = 32'h09FB385B;
                3:  v = 32'h051111D4;
                4:  v = 32'h028B0D43;
                5:  v = 32'h0145D7E1;
                6:  v = 32'h00A2F61E;
                7:  v = 32'h00517C55;
                8:  v = 32'h0028BE53;
                9:  v = 32'h00145F2E;
                10: v = 32'h000A2F98;
                11: v = 32'h000517CC;
                12: v = 32'h00028BE6;
                13: v = 32'h000145F3;
                14: v = 32'h0000A2F9;
                15: v = 32'h0000517C;
                16: v = 32'h000028BE;
                17: v = 32'h0000145F;
                18: v = 32'h00000A2F;
                19: v = 32'h00000517;
                20: v = 32'h0000028B;
                21: v = 32'h00000145;
                22: v = 32'h000000A2;
                23: v = 32'h00000051;
                24: v = 32'h00000028;
                25: v = 32'h00000014;
                26: v = 32'h0000000A;
                27: v = 32'h00000005;
                28: v = 32'h00000002;
                29: v = 32'h00000001;
                default: v = 32'h00000000;
            endcase
            atan_entry = $signed({2'b00, v});
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        begin
            if (v > 34'sd2147483647)
                sat32 = 32'sh7FFFFFFF;
            else if (v < -34'sd2147483648)
                sat32 = 32'sh80000000;
            else
                sat32 = v[31:0];
        end
    endfunction

endpackage

@@ sv/ddo_cell.sv @@
// One CORDIC micro-rotation cell with a fixed shift and arctangent constant.
module ddo_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [4:0]           shift,
    input  logic                 vld_in,
    input  ddo_pkg::cordic_vec_t vec_in,
    output logic                 vld_out,
    output ddo_pkg::cordic_vec_t vec_out
);

    ddo_pkg::cordic_vec_t vec_reg, vec_next;
    logic                 vld_reg;
    logic signed [33:0]   xs, ys, atn;

    always_comb
    begin
        xs  = vec_in.x >>> shift;
        ys  = vec_in.y >>> shift;
        atn = ddo_pkg::atan_entry(int'(shift));
        if (!vec_in.z[33])
        begin
            vec_next.x = vec_in.x - ys;
            vec_next.y = vec_in.y + xs;
            vec_next.z = vec_in.z - atn;
        end
        else
        begin
            vec_next.x = vec_in.x + ys;
            vec_next.y = vec_in.y - xs;
            vec_next.z = vec_in.z + atn;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (vld_in)
            vec_reg <= vec_next;
    end

    assign vld_out = vld_reg;
    assign vec_out = vec_reg;

endmodule

@@ sv/differential_drive_odometry.sv @@
// Top level: differential-drive odometry with a chain of CORDIC cells.
// States in order: S_MUL, S_ROT (CORDIC cell chain), S_QUAD, S_PROD, S_OUT, then back to S_IDLE.
// A new transaction is taken only in S_IDLE, so none enters before the last one has left S_OUT.
// S_OUT waits until the output register is empty or its result is being taken.
// Reset clears pose, heading, distance and restores both config registers.
`include "assert_macros.svh"
module differential_drive_odometry (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  ddo_pkg::in_item_t      in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output ddo_pkg::out_item_t     out_data,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MUL   = 6'b000010,
        S_ROT   = 6'b000100,
        S_QUAD  = 6'b001000,
        S_PROD  = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [23:0] dpt_reg, hpt_reg;
    logic signed [31:0] px_reg, py_reg, trav_reg;
    logic [31:0] head_reg;
    logic signed [17:0] sum_reg, diff_reg;
    logic clr_reg;
    logic signed [33:0] ds_reg;
    logic [1:0] quad_reg;
    logic signed [33:0] cos_reg, sin_reg;
    logic signed [67:0] px_prod, py_prod;
    logic signed [33:0] dx_reg, dy_reg;
    ddo_pkg::out_item_t out_reg;
    logic out_vld_reg;

    logic signed [16:0] r_w, l_w;
    logic wr;
    logic signed [41:0] ds_full;
    logic [31:0] dh, head_new;
    logic [31:0] zres;
    logic [1:0] q_new;

    logic                 chain_vld [0:ddo_pkg::NumCells];
    ddo_pkg::cordic_vec_t chain_vec [0:ddo_pkg::NumCells];

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[2])
            ddo_pkg::RegDistancePerTic[0]: prdata = {8'd0, dpt_reg};
            default:                       prdata = {8'd0, hpt_reg};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dpt_reg <= ddo_pkg::DptReset;
            hpt_reg <= ddo_pkg::HptReset;
        end
        else if (wr)
        begin
            if (paddr[2] == ddo_pkg::RegDistancePerTic[0])
                dpt_reg <= pwdata[23:0];
            else
                hpt_reg <= pwdata[23:0];
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        r_w = in_data.right_reverse ? -{in_data.right_tics[15], in_data.right_tics}
                                    :  {in_data.right_tics[15], in_data.right_tics};
        l_w = in_data.left_reverse  ? -{in_data.left_tics[15], in_data.left_tics}
                                    :  {in_data.left_tics[15], in_data.left_tics};
    end

    assign ds_full  = (42'(sum_reg) * $signed({18'd0, dpt_reg})) + 42'sd256;
    assign dh       = 32'(42'(diff_reg) * $signed({18'd0, hpt_reg}));
    assign head_new = head_reg + dh;
    assign q_new    = 2'(({2'b00, head_new} + 34'h20000000) >> 30);
    assign zres     = head_new - {q_new, 30'd0};

    assign chain_vld[0]   = (state_reg == S_MUL);
    assign chain_vec[0].x = ddo_pkg::GainQ30;
    assign chain_vec[0].y = 34'sd0;
    assign chain_vec[0].z = {{2{zres[31]}}, zres};

    genvar g;
    generate
        for (g = 0; g < ddo_pkg::NumCells; g++)
        begin : g_cell
            ddo_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .shift   (5'(g)),
                .vld_in  (chain_vld[g]),
                .vec_in  (chain_vec[g]),
                .vld_out (chain_vld[g+1]),
                .vec_out (chain_vec[g+1])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (in_valid) state_next = S_MUL;
            S_MUL:  state_next = S_ROT;
            S_ROT:  if (chain_vld[ddo_pkg::NumCells]) state_next = S_QUAD;
            S_QUAD: state_next = S_PROD;
            S_PROD: state_next = S_OUT;
            S_OUT:  if (!out_vld_reg || out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            px_reg      <= '0;
            py_reg      <= '0;
            head_reg    <= '0;
            trav_reg    <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_OUT && (!out_vld_reg || out_ready))
                out_vld_reg <= 1'b1;
            else if (out_ready)
                out_vld_reg <= 1'b0;
            case (state_reg)
                S_MUL:
                begin
                    head_reg <= head_new;
                    trav_reg <= ddo_pkg::sat32((clr_reg ? 34'sd0 : 34'(trav_reg))
                                               + 34'(ds_full >>> 9));
                end
                S_OUT:
                begin
                    if (!out_vld_reg || out_ready)
                    begin
                        px_reg      <= ddo_pkg::sat32(34'(px_reg) + 34'(dx_reg));
                        py_reg      <= ddo_pkg::sat32(34'(py_reg) + 34'(dy_reg));
                    end
                end
                default: ;
            endcase
        end
    end

    assign px_prod = ds_reg * cos_reg + (68'sd1 <<< 29);
    assign py_prod = ds_reg * sin_reg + (68'sd1 <<< 29);

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            sum_reg  <= r_w + l_w;
            diff_reg <= r_w - l_w;
            clr_reg  <= in_data.clear_distance;
        end
        if (state_reg == S_MUL)
        begin
            ds_reg   <= 34'(ds_full >>> 9);
            quad_reg <= q_new;
        end
        if (state_reg == S_QUAD)
        begin
            case (quad_reg)
                2'd0:    begin cos_reg <=  chain_vec[ddo_pkg::NumCells].x;
                               sin_reg <=  chain_vec[ddo_pkg::NumCells].y; end
                2'd1:    begin cos_reg <= -chain_vec[ddo_pkg::NumCells].y;
                               sin_reg <=  chain_vec[ddo_pkg::NumCells].x; end
                2'd2:    begin cos_reg <= -chain_vec[ddo_pkg::NumCells].x;
                               sin_reg <= -chain_vec[ddo_pkg::NumCells].y; end
                default: begin cos_reg <=  chain_vec[ddo_pkg::NumCells].y;
                               sin_reg <= -chain_vec[ddo_pkg::NumCells].x; end
            endcase
        end
        if (state_reg == S_PROD)
        begin
            dx_reg  <= 34'(px_prod >>> 30);
            dy_reg  <= 34'(py_prod >>> 30);
        end
        if (state_reg == S_OUT && (!out_vld_reg || out_ready))
        begin
            out_reg.position_x    <= ddo_pkg::sat32(34'(px_reg) + 34'(dx_reg));
            out_reg.position_y    <= ddo_pkg::sat32(34'(py_reg) + 34'(dy_reg));
            out_reg.heading_angle <= head_reg;
            out_reg.path_distance <= trav_reg;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

    `ASSERT_NEXT(a_accept_starts, clk, rst_n, in_valid && in_ready, state_reg == S_MUL)
    `ASSERT_IMPLY(a_chain_only_rot, clk, rst_n, chain_vld[ddo_pkg::NumCells],
                  state_reg == S_ROT)
    `ASSERT_NEXT(a_out_holds, clk, rst_n, out_valid && !out_ready, out_valid)

endmodule
